// ----- hdl/inv_pkg.sv -----
`timescale 1ns / 1ps

package inv_pkg;

	// Scanner states
	localparam logic [2:0] ST_START = 3'd0;  // start of a segment
	localparam logic [2:0] ST_UNDER = 3'd1;  // after an opening underscore
	localparam logic [2:0] ST_WORD  = 3'd2;  // middle of a word
	localparam logic [2:0] ST_PCT   = 3'd3;  // after a percent sign
	localparam logic [2:0] ST_DOC   = 3'd4;  // inside wildcard documentation

	// Character codes
	localparam logic [7:0] CH_UNDERSCORE  = 8'h5F;
	localparam logic [7:0] CH_PERCENT     = 8'h25;
	localparam logic [7:0] CH_LOWER_D     = 8'h64;
	localparam logic [7:0] CH_OPEN_PAREN  = 8'h28;
	localparam logic [7:0] CH_CLOSE_PAREN = 8'h29;
	localparam logic [7:0] CH_DOT         = 8'h2E;

	// Configuration register indexes
	localparam logic [1:0] REG_WILDCARD_ENABLE = 2'd0;
	localparam logic [1:0] REG_DOT_ENABLE      = 2'd1;

	// Result of one scanner step
	typedef struct packed {
		logic res_valid;
		logic name_ok;
	} scan_res_t;

endpackage

// ----- hdl/inv_scanner.sv -----
`timescale 1ns / 1ps

module inv_scanner (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step_en,
	input  logic [7:0]         char_code,
	input  logic               is_last,
	input  logic               is_empty,
	input  logic               wildcard_enable,
	input  logic               dot_enable,
	output inv_pkg::scan_res_t res
);
	import inv_pkg::*;

	logic [2:0] scan_state_q;
	logic       may_end_q;
	logic       rejected_q;

	logic [2:0] state_nx;
	logic       may_end_nx;
	logic       rejected_nx;
	logic       letter;
	logic       digit;

	assign letter = char_code inside {[8'h61:8'h7A], [8'h41:8'h5A]};
	assign digit  = char_code inside {[8'h30:8'h39]};

	// One character step; a rejected name holds its state
	always_comb begin
		state_nx    = scan_state_q;
		may_end_nx  = may_end_q;
		rejected_nx = rejected_q;
		if (!rejected_q) begin
			case (scan_state_q)
				ST_START: begin
					if (char_code == CH_UNDERSCORE) begin
						state_nx   = ST_UNDER;
						may_end_nx = 1'b0;
					end else if (letter) begin
						state_nx   = ST_WORD;
						may_end_nx = 1'b1;
					end else begin
						rejected_nx = 1'b1;
					end
				end
				ST_UNDER: begin
					if (wildcard_enable && char_code == CH_PERCENT) begin
						state_nx   = ST_PCT;
						may_end_nx = 1'b0;
					end else if (letter || digit) begin
						state_nx   = ST_WORD;
						may_end_nx = 1'b1;
					end else begin
						rejected_nx = 1'b1;
					end
				end
				ST_WORD: begin
					if (dot_enable && char_code == CH_DOT) begin
						state_nx   = ST_START;
						may_end_nx = 1'b0;
					end else if (wildcard_enable && char_code == CH_PERCENT) begin
						state_nx   = ST_PCT;
						may_end_nx = 1'b0;
					end else if (letter || digit || char_code == CH_UNDERSCORE) begin
						may_end_nx = 1'b1;
					end else begin
						rejected_nx = 1'b1;
					end
				end
				ST_PCT: begin
					if (char_code == CH_LOWER_D) begin
						state_nx   = ST_WORD;
						may_end_nx = 1'b1;
					end else if (char_code == CH_OPEN_PAREN) begin
						state_nx   = ST_DOC;
						may_end_nx = 1'b0;
					end else begin
						rejected_nx = 1'b1;
					end
				end
				ST_DOC: begin
					may_end_nx = 1'b0;
					if (char_code == CH_CLOSE_PAREN)
						state_nx = ST_PCT;
				end
				default: begin
					rejected_nx = 1'b1;
				end
			endcase
		end
	end

	// Result on the last character or an empty name
	always_comb begin
		res.res_valid = step_en && (is_last || is_empty);
		res.name_ok   = !is_empty && may_end_nx && !rejected_nx;
	end

	// Scanner state; cleared at the end of every name
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_state_q <= ST_START;
			may_end_q    <= 1'b0;
			rejected_q   <= 1'b0;
		end else if (step_en) begin
			if (is_last || is_empty) begin
				scan_state_q <= ST_START;
				may_end_q    <= 1'b0;
				rejected_q   <= 1'b0;
			end else begin
				scan_state_q <= state_nx;
				may_end_q    <= may_end_nx;
				rejected_q   <= rejected_nx;
			end
		end
	end

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && (is_last || is_empty) |=> scan_state_q == ST_START && !rejected_q
			&& !may_end_q)
		else $error("scanner not cleared after end of name");

	a_reject_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		rejected_q && !(step_en && (is_last || is_empty)) |=> rejected_q)
		else $error("reject flag dropped inside a name");

	a_may_end_word: assert property (@(posedge clk) disable iff (!arst_n)
		may_end_q |-> scan_state_q == ST_WORD)
		else $error("may_end set outside a word");

	a_ok_needs_end: assert property (@(posedge clk) disable iff (!arst_n)
		res.res_valid && res.name_ok |-> !rejected_q && !is_empty)
		else $error("valid name reported after a reject");

endmodule

// ----- hdl/identifier_name_validator_top.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Signals                            Contents
// s_axis    in         tvalid tready tdata tlast tuser    char_code, is_last, is_empty
// m_axis    out        tvalid tready tdata                name_ok
// cfg       in         valid ready index data             0 wildcard_enable, 1 dot_enable
//
// One character per cycle sustained unless the result stalls; a character
// passes an input register and the scanner step into the result register.
// arst_n clears the scanner, both enables and all valid flags.
// A stalled result holds the pipeline; input is taken whenever the input
// register is empty or moves on in the same cycle.
// Configuration writes are always taken and apply from the next character.

module identifier_name_validator_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] char_code
	input  logic       s_axis_tlast,   // is_last
	input  logic       s_axis_tuser,   // is_empty
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [0] name_ok, [7:1] zero
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic       cfg_data
);
	import inv_pkg::*;

	logic       wildcard_enable_q;
	logic       dot_enable_q;
	logic       s1_valid_q;
	logic [7:0] s1_char;
	logic       s1_last;
	logic       s1_empty;
	logic       out_valid_q;
	logic       name_ok_q;
	logic       advance;
	scan_res_t  res;

	assign cfg_ready     = 1'b1;
	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !s1_valid_q || advance;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wildcard_enable_q <= 1'b0;
			dot_enable_q      <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_WILDCARD_ENABLE: wildcard_enable_q <= cfg_data;
				REG_DOT_ENABLE:      dot_enable_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_q <= 1'b0;
		else if (s_axis_tready)
			s1_valid_q <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			s1_char  <= s_axis_tdata;
			s1_last  <= s_axis_tlast;
			s1_empty <= s_axis_tuser;
		end
	end

	inv_scanner u_scanner (
		.clk             (clk),
		.arst_n          (arst_n),
		.step_en         (s1_valid_q && advance),
		.char_code       (s1_char),
		.is_last         (s1_last),
		.is_empty        (s1_empty),
		.wildcard_enable (wildcard_enable_q),
		.dot_enable      (dot_enable_q),
		.res             (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= res.res_valid;
	end

	always_ff @(posedge clk) begin
		if (advance && res.res_valid)
			name_ok_q <= res.name_ok;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, name_ok_q};

	a_idle_drains: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_valid_q && m_axis_tready |=> !out_valid_q)
		else $error("result appeared without an item");

	a_result_from_end: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && advance && !s1_last && !s1_empty |=> !out_valid_q)
		else $error("result from a middle character");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !advance |=> s1_valid_q && $stable(s1_char))
		else $error("input register lost an item under stall");

endmodule

// ----- tb/tb_identifier_name_validator_top.sv -----
`timescale 1ns / 1ps

module tb_identifier_name_validator_top;
	import inv_pkg::*;

	// Character ranges used by the name generator
	localparam logic [7:0] CH_LC_A = 8'h61;
	localparam logic [7:0] CH_UC_A = 8'h41;
	localparam logic [7:0] CH_ZERO = 8'h30;

	// Register indexes that decode to nothing
	localparam logic [1:0] REG_SPARE_2 = 2'd2;
	localparam logic [1:0] REG_SPARE_3 = 2'd3;

	// Drain wait after the last expected result, with margin
	localparam int DRAIN_CYCLES = 4;

	logic       clk;
	logic       arst_n;
	logic       s_axis_tvalid;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata;   // [7:0] char_code
	logic       s_axis_tlast;   // is_last
	logic       s_axis_tuser;   // is_empty
	logic       m_axis_tvalid;
	logic       m_axis_tready;
	logic [7:0] m_axis_tdata;   // [0] name_ok, [7:1] zero
	logic       cfg_valid;
	logic       cfg_ready;
	logic [1:0] cfg_index;
	logic       cfg_data;

	// Scanner mirror and register copies
	logic [2:0] scan_st;
	logic       can_end;
	logic       bad_seen;
	logic       wc_en;
	logic       dot_en;

	logic       expected_ok[$];
	logic [7:0] name_chars[$];
	logic       exp_name_ok;
	int         mismatches;
	int         items_sent;
	bit         src_idle_on;
	bit         sink_idle_on;
	int         sink_hold_left;
	int         sink_gap_left;

	identifier_name_validator_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// ---------------------------------------------------------------
	// Scanner prediction
	// ---------------------------------------------------------------
	function automatic bit is_letter(input logic [7:0] c);
		return (c >= CH_LC_A && c <= CH_LC_A + 8'd25) || (c >= CH_UC_A && c <= CH_UC_A + 8'd25);
	endfunction

	function automatic bit is_digit(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_ZERO + 8'd9;
	endfunction

	function automatic void clear_scan();
		scan_st  = ST_START;
		can_end  = 1'b0;
		bad_seen = 1'b0;
	endfunction

	function automatic void scan_step(input logic [7:0] c, input logic last, input logic empty);
		if (empty) begin
			expected_ok.push_back(1'b0);
			clear_scan();
			return;
		end
		// a rejected name only waits for its last character
		if (!bad_seen) begin
			case (scan_st)
				ST_START: begin
					if (c == CH_UNDERSCORE) begin
						scan_st = ST_UNDER;
						can_end = 1'b0;
					end else if (is_letter(c)) begin
						scan_st = ST_WORD;
						can_end = 1'b1;
					end else begin
						bad_seen = 1'b1;
					end
				end
				ST_UNDER: begin
					if (wc_en && c == CH_PERCENT) begin
						scan_st = ST_PCT;
						can_end = 1'b0;
					end else if (is_letter(c) || is_digit(c)) begin
						scan_st = ST_WORD;
						can_end = 1'b1;
					end else begin
						bad_seen = 1'b1;
					end
				end
				ST_WORD: begin
					if (dot_en && c == CH_DOT) begin
						scan_st = ST_START;
						can_end = 1'b0;
					end else if (wc_en && c == CH_PERCENT) begin
						scan_st = ST_PCT;
						can_end = 1'b0;
					end else if (is_letter(c) || is_digit(c) || c == CH_UNDERSCORE) begin
						can_end = 1'b1;
					end else begin
						bad_seen = 1'b1;
					end
				end
				ST_PCT: begin
					if (c == CH_LOWER_D) begin
						scan_st = ST_WORD;
						can_end = 1'b1;
					end else if (c == CH_OPEN_PAREN) begin
						scan_st = ST_DOC;
						can_end = 1'b0;
					end else begin
						bad_seen = 1'b1;
					end
				end
				ST_DOC: begin
					can_end = 1'b0;
					if (c == CH_CLOSE_PAREN)
						scan_st = ST_PCT;
				end
				default: bad_seen = 1'b1;
			endcase
		end
		if (last) begin
			expected_ok.push_back(can_end && !bad_seen);
			clear_scan();
		end
	endfunction

	// ---------------------------------------------------------------
	// Name generator
	// ---------------------------------------------------------------
	function automatic logic [7:0] pick_letter();
		logic [7:0] ofs;
		ofs = 8'($urandom_range(0, 25));
		return ($urandom_range(0, 1) != 0) ? CH_LC_A + ofs : CH_UC_A + ofs;
	endfunction

	function automatic logic [7:0] pick_alnum();
		if ($urandom_range(0, 2) == 0)
			return CH_ZERO + 8'($urandom_range(0, 9));
		return pick_letter();
	endfunction

	function automatic logic [7:0] pick_special();
		case ($urandom_range(0, 5))
			0: return CH_UNDERSCORE;
			1: return CH_PERCENT;
			2: return CH_LOWER_D;
			3: return CH_OPEN_PAREN;
			4: return CH_CLOSE_PAREN;
			default: return CH_DOT;
		endcase
	endfunction

	// percent-d, sometimes with one or two documentation groups
	function automatic void add_wildcard();
		int groups;
		int doc_len;
		name_chars.push_back(CH_PERCENT);
		groups = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(1, 2);
		for (int g = 0; g < groups; g++) begin
			name_chars.push_back(CH_OPEN_PAREN);
			doc_len = $urandom_range(0, 4);
			for (int i = 0; i < doc_len; i++) begin
				logic [7:0] b;
				b = 8'($urandom);
				name_chars.push_back(b == CH_CLOSE_PAREN ? CH_DOT : b);
			end
			name_chars.push_back(CH_CLOSE_PAREN);
		end
		name_chars.push_back(CH_LOWER_D);
	endfunction

	// well-formed name for the current register settings
	function automatic void build_name();
		int segs;
		int body_len;
		name_chars.delete();
		segs = dot_en ? $urandom_range(1, 3) : 1;
		for (int s = 0; s < segs; s++) begin
			if (s > 0)
				name_chars.push_back(CH_DOT);
			if ($urandom_range(0, 3) == 0) begin
				name_chars.push_back(CH_UNDERSCORE);
				if (wc_en && $urandom_range(0, 2) == 0)
					add_wildcard();
				else
					name_chars.push_back(pick_alnum());
			end else begin
				name_chars.push_back(pick_letter());
			end
			body_len = $urandom_range(0, 5);
			for (int i = 0; i < body_len; i++) begin
				if (wc_en && $urandom_range(0, 5) == 0)
					add_wildcard();
				else if ($urandom_range(0, 5) == 0)
					name_chars.push_back(CH_UNDERSCORE);
				else
					name_chars.push_back(pick_alnum());
			end
		end
	endfunction

	// ---------------------------------------------------------------
	// Stimulus tasks
	// ---------------------------------------------------------------
	task automatic send_char(input logic [7:0] c, input logic last, input logic empty);
		if (src_idle_on && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= c;
		s_axis_tlast  <= last;
		s_axis_tuser  <= empty;
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
		scan_step(c, last, empty);
	endtask

	task automatic send_name(input string s, input bit finish_name);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], finish_name && (i == s.len() - 1), 1'b0);
	endtask

	task automatic send_empty();
		send_char(8'($urandom), 1'($urandom), 1'b1);
	endtask

	task automatic send_queued(input bit finish_name);
		for (int i = 0; i < name_chars.size(); i++)
			send_char(name_chars[i], finish_name && (i == name_chars.size() - 1), 1'b0);
	endtask

	// mostly well-formed names, the rest empty items, corrupted, abandoned or plain noise
	task automatic send_random_name();
		int kind;
		int n;
		kind = $urandom_range(0, 19);
		if (kind == 0) begin
			send_empty();
			return;
		end
		build_name();
		if (kind <= 3) begin
			name_chars[$urandom_range(0, name_chars.size() - 1)] = 8'($urandom);
		end else if (kind <= 5) begin
			name_chars[$urandom_range(0, name_chars.size() - 1)] = pick_special();
		end else if (kind == 6) begin
			name_chars.delete();
			n = $urandom_range(1, 6);
			for (int i = 0; i < n; i++)
				name_chars.push_back(($urandom_range(0, 1) != 0) ? 8'($urandom) : pick_special());
		end else if (kind == 7) begin
			// name cut off by an empty item
			send_queued(1'b0);
			send_empty();
			return;
		end
		send_queued(1'b1);
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (expected_ok.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic val);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_WILDCARD_ENABLE: wc_en = val;
			REG_DOT_ENABLE:      dot_en = val;
			default: ;
		endcase
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------
	task automatic test_directed_plain();
		src_idle_on  = 1'b0;
		sink_idle_on = 1'b0;
		send_name("a", 1'b1);
		send_name("_", 1'b1);
		send_name("_9", 1'b1);
		send_name("Z0_", 1'b1);
		send_empty();
		// empty item abandons a name in progress
		send_name("q", 1'b0);
		send_empty();
		send_char(8'hFF, 1'b1, 1'b0);
		// sticky reject: bad first char, good last char
		send_char(8'h00, 1'b0, 1'b0);
		send_name("a", 1'b1);
		// dot not allowed yet
		send_name("a.", 1'b1);
	endtask

	task automatic test_directed_extended();
		// enables written while a name is open apply from the next char
		send_name("x", 1'b0);
		write_reg(REG_DOT_ENABLE, 1'b1);
		write_reg(REG_WILDCARD_ENABLE, 1'b1);
		send_name(".y", 1'b1);
		send_name("_%d", 1'b1);
		send_name("x%(.)d", 1'b1);
		send_name("a.", 1'b1);
		send_name("b%", 1'b1);
	endtask

	task automatic test_config_sweep();
		logic [1:0] setting;
		int         phase_end;
		for (int k = 0; k < 4; k++) begin
			setting = (k == 0) ? 2'b00 : (k == 1) ? 2'b11 : (k == 2) ? 2'b01 : 2'b10;
			if ($urandom_range(0, 1) != 0) begin
				write_reg(REG_WILDCARD_ENABLE, setting[0]);
				write_reg(REG_DOT_ENABLE, setting[1]);
			end else begin
				write_reg(REG_DOT_ENABLE, setting[1]);
				write_reg(REG_WILDCARD_ENABLE, setting[0]);
			end
			// unmapped indexes must leave both enables alone
			write_reg(REG_SPARE_2, 1'($urandom));
			write_reg(REG_SPARE_3, 1'($urandom));
			src_idle_on  = (k != 1);
			sink_idle_on = (k != 2);
			phase_end = items_sent + 80;
			while (items_sent < phase_end)
				send_random_name();
		end
	endtask

	task automatic test_backpressure();
		int stop_at;
		src_idle_on    = 1'b0;
		sink_idle_on   = 1'b0;
		sink_hold_left = 300;
		stop_at = items_sent + 40;
		while (items_sent < stop_at) begin
			if ($urandom_range(0, 1) != 0)
				send_empty();
			else
				send_random_name();
		end
	endtask

	task automatic test_no_idle_tail();
		int stop_at;
		write_reg(REG_WILDCARD_ENABLE, 1'b1);
		write_reg(REG_DOT_ENABLE, 1'b1);
		src_idle_on  = 1'b0;
		sink_idle_on = 1'b0;
		stop_at = items_sent + 60;
		while (items_sent < stop_at)
			send_random_name();
	endtask

	// ---------------------------------------------------------------
	// Result sink: random stalls plus a long hold-off on request
	// ---------------------------------------------------------------
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (sink_hold_left > 0) begin
				sink_hold_left--;
				m_axis_tready <= 1'b0;
			end else if (sink_gap_left > 0) begin
				sink_gap_left--;
				m_axis_tready <= 1'b0;
			end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
				sink_gap_left = $urandom_range(0, 14);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Result check against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_ok.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual tdata=%h",
					$time, m_axis_tdata);
				mismatches++;
			end else begin
				exp_name_ok = expected_ok.pop_front();
				if (m_axis_tdata !== {7'd0, exp_name_ok}) begin
					$display("%0t: name_ok mismatch: expected tdata=%h, actual tdata=%h",
						$time, {7'd0, exp_name_ok}, m_axis_tdata);
					mismatches++;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin
		arst_n         = 1'b0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = 8'd0;
		s_axis_tlast   = 1'b0;
		s_axis_tuser   = 1'b0;
		cfg_valid      = 1'b0;
		cfg_index      = REG_WILDCARD_ENABLE;
		cfg_data       = 1'b0;
		mismatches     = 0;
		items_sent     = 0;
		src_idle_on    = 1'b0;
		sink_idle_on   = 1'b0;
		sink_hold_left = 0;
		sink_gap_left  = 0;
		wc_en          = 1'b0;
		dot_en         = 1'b0;
		clear_scan();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_plain();
		test_directed_extended();
		test_config_sweep();
		test_backpressure();
		test_no_idle_tail();

		s_axis_tvalid <= 1'b0;
		while (expected_ok.size() != 0) @(posedge clk);
		repeat (2 * DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_ok.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// ----- identifier_name_validator_top.f -----
hdl/inv_pkg.sv
hdl/inv_scanner.sv
hdl/identifier_name_validator_top.sv
tb/tb_identifier_name_validator_top.sv
